[rtl/sbda_pkg.sv]
// Shared constants, types and state encoding for the signed binary to decimal ASCII converter.
package sbda_pkg;

	localparam int VALUE_W       = 32;
	localparam int CHAR_W        = 8;
	localparam int DIGIT_W       = 4;
	localparam int NUM_DIGITS    = 10;
	localparam int MAX_CHARS_DEF = 12;
	localparam int CFG_SIZE_W    = 4;
	localparam int APB_ADDR_W    = 3;
	localparam int APB_DATA_W    = 32;

	localparam logic [CFG_SIZE_W-1:0] BUFFER_SIZE_RST = CFG_SIZE_W'(12);
	localparam logic [APB_ADDR_W-3:0] REG_BUFFER_SIZE = '0;

	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_SKIP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clear;
		logic dabble;
		logic dshift;
	} cell_ctrl_t;

endpackage

[rtl/signed_binary_to_decimal_ascii.sv]
// Top level: signed 32-bit integer to decimal ASCII character stream with APB size register.
//
// channel   signals                                   payload
// -------   ---------------------------------------   -------------------
// input     value_valid / value_ready                 value[31:0] signed
// output    char_valid / char_ready                   char_code[7:0], last
// config    psel penable pwrite paddr pwdata prdata   buffer_size[3:0]
//
// One value at a time: an accept step, double-dabble steps through the digit cell row,
// a sign step, then leading-zero shifts, a step to leave the skip and one character
// per cycle while the output does not stall. A smaller buffer_size shortens the emit phase.
// Output stalls hold the sequencer; a buffer_size of 0 drops the value on accept.
// arst_n clears control state and sets buffer_size to 12.
module signed_binary_to_decimal_ascii #(
	parameter int MAX_CHARS = sbda_pkg::MAX_CHARS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic signed [sbda_pkg::VALUE_W-1:0] value,
	input  logic                              value_valid,
	output logic                              value_ready,
	output logic [sbda_pkg::CHAR_W-1:0]       char_code,
	output logic                              last,
	output logic                              char_valid,
	input  logic                              char_ready,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [sbda_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [sbda_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [sbda_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);

	localparam int CAP_W  = $clog2(MAX_CHARS + 1);
	localparam int CMP_W  = sbda_pkg::CFG_SIZE_W + CAP_W;
	localparam int CNT_W  = $clog2(sbda_pkg::VALUE_W);
	localparam int LEFT_W = $clog2(sbda_pkg::NUM_DIGITS + 1);
	localparam int ND     = sbda_pkg::NUM_DIGITS;
	localparam int DW     = sbda_pkg::DIGIT_W;

	sbda_pkg::state_t state_q, state_d;
	sbda_pkg::cell_ctrl_t ctrl;

	logic [sbda_pkg::CFG_SIZE_W-1:0] buffer_size_q;
	logic [sbda_pkg::VALUE_W-1:0]    mag_q;
	logic                            neg_q;
	logic [CNT_W-1:0]                cnt_q;
	logic [LEFT_W-1:0]               left_q;
	logic [CAP_W-1:0]                vis_q, cap_q, cap_in;
	logic [sbda_pkg::CHAR_W-1:0]     char_q;
	logic                            last_q, out_valid_q;

	logic                            load, emit, emit_last, vis_inc, left_dec;
	logic [sbda_pkg::CHAR_W-1:0]     emit_char;
	logic                            out_free, room;
	logic                            cfg_wr, cfg_hit;

	logic                            cell_bit [ND+1];
	logic [DW-1:0]                   cell_digit [ND];
	logic [DW-1:0]                   top_digit;

	// configuration
	assign pready  = 1'b1;
	assign cfg_hit = paddr[sbda_pkg::APB_ADDR_W-1:2] == sbda_pkg::REG_BUFFER_SIZE;
	assign cfg_wr  = psel & penable & pwrite & pready & cfg_hit;
	assign prdata  = cfg_hit ? sbda_pkg::APB_DATA_W'(buffer_size_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_size_q <= sbda_pkg::BUFFER_SIZE_RST;
		end else if (cfg_wr) begin
			buffer_size_q <= pwdata[sbda_pkg::CFG_SIZE_W-1:0];
		end
	end

	assign cap_in = (CMP_W'(buffer_size_q) > CMP_W'(MAX_CHARS)) ? CAP_W'(MAX_CHARS)
	                                                           : CAP_W'(buffer_size_q);

	// digit cell row
	assign cell_bit[0] = mag_q[sbda_pkg::VALUE_W-1];

	for (genvar i = 0; i < ND; i++) begin : g_cell
		sbda_digit_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.bit_in   (cell_bit[i]),
			.digit_in ((i == 0) ? DW'(0) : cell_digit[(i == 0) ? 0 : i-1]),
			.bit_out  (cell_bit[i+1]),
			.digit    (cell_digit[i])
		);
	end

	assign top_digit = cell_digit[ND-1];

	// sequencer
	assign out_free    = !out_valid_q || char_ready;
	assign room        = ((CAP_W+1)'(vis_q) + (CAP_W+1)'(1)) < (CAP_W+1)'(cap_q);
	assign value_ready = state_q == sbda_pkg::ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctrl      = '0;
		load      = 1'b0;
		emit      = 1'b0;
		emit_char = sbda_pkg::CH_NUL;
		emit_last = 1'b0;
		vis_inc   = 1'b0;
		left_dec  = 1'b0;
		unique case (state_q)
			sbda_pkg::ST_IDLE: begin
				if (value_valid && cap_in != '0) begin
					load       = 1'b1;
					ctrl.clear = 1'b1;
					state_d    = sbda_pkg::ST_CONV;
				end
			end
			sbda_pkg::ST_CONV: begin
				ctrl.dabble = 1'b1;
				if (cnt_q == CNT_W'(sbda_pkg::VALUE_W - 1)) begin
					state_d = sbda_pkg::ST_SIGN;
				end
			end
			sbda_pkg::ST_SIGN: begin
				if (neg_q && room) begin
					if (out_free) begin
						emit      = 1'b1;
						emit_char = sbda_pkg::CH_MINUS;
						vis_inc   = 1'b1;
						state_d   = sbda_pkg::ST_SKIP;
					end
				end else begin
					state_d = sbda_pkg::ST_SKIP;
				end
			end
			sbda_pkg::ST_SKIP: begin
				if (top_digit == '0 && left_q > LEFT_W'(1)) begin
					ctrl.dshift = 1'b1;
					left_dec    = 1'b1;
				end else begin
					state_d = sbda_pkg::ST_EMIT;
				end
			end
			sbda_pkg::ST_EMIT: begin
				if (out_free) begin
					emit = 1'b1;
					if (left_q != '0 && room) begin
						emit_char   = sbda_pkg::CH_ZERO + sbda_pkg::CHAR_W'(top_digit);
						ctrl.dshift = 1'b1;
						left_dec    = 1'b1;
						vis_inc     = 1'b1;
					end else begin
						emit_last = 1'b1;
						state_d   = sbda_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = sbda_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			neg_q <= value[sbda_pkg::VALUE_W-1];
			mag_q <= value[sbda_pkg::VALUE_W-1] ? (~value + sbda_pkg::VALUE_W'(1)) : value;
			cap_q <= cap_in;
		end else if (state_q == sbda_pkg::ST_CONV) begin
			mag_q <= {mag_q[sbda_pkg::VALUE_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			left_q <= '0;
			vis_q  <= '0;
		end else begin
			if (load) begin
				cnt_q  <= '0;
				left_q <= LEFT_W'(ND);
				vis_q  <= '0;
			end else begin
				if (state_q == sbda_pkg::ST_CONV) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (left_dec) begin
					left_q <= left_q - LEFT_W'(1);
				end
				if (vis_inc) begin
					vis_q <= vis_q + CAP_W'(1);
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (char_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= emit_char;
			last_q <= emit_last;
		end
	end

	assign char_valid = out_valid_q;
	assign char_code  = char_q;
	assign last       = last_q;

	// checks
	a_new_char_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(char_valid) |-> ($past(state_q) == sbda_pkg::ST_SIGN ||
		                       $past(state_q) == sbda_pkg::ST_EMIT))
		else $error("character produced outside sign or emit phase");

	a_vis_under_cap: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sbda_pkg::ST_EMIT |-> vis_q < cap_q)
		else $error("visible count reached buffer cap");

	a_skip_keeps_digit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sbda_pkg::ST_SKIP |-> left_q != '0)
		else $error("leading-zero skip consumed every digit");

	a_bcd_digit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sbda_pkg::ST_EMIT |-> top_digit <= DW'(9))
		else $error("digit cell holds a non-decimal code");

endmodule

[rtl/sbda_digit_cell.sv]
// One BCD digit cell: add-3 and shift during conversion, whole-digit shift during output.
module sbda_digit_cell (
	input  logic                             clk,
	input  sbda_pkg::cell_ctrl_t             ctrl,
	input  logic                             bit_in,
	input  logic [sbda_pkg::DIGIT_W-1:0]     digit_in,
	output logic                             bit_out,
	output logic [sbda_pkg::DIGIT_W-1:0]     digit
);

	logic [sbda_pkg::DIGIT_W-1:0] digit_q;
	logic [sbda_pkg::DIGIT_W-1:0] adj;

	assign adj     = (digit_q >= sbda_pkg::DIGIT_W'(5)) ? digit_q + sbda_pkg::DIGIT_W'(3) : digit_q;
	assign bit_out = adj[sbda_pkg::DIGIT_W-1];
	assign digit   = digit_q;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.dabble) begin
			digit_q <= {adj[sbda_pkg::DIGIT_W-2:0], bit_in};
		end else if (ctrl.dshift) begin
			digit_q <= digit_in;
		end
	end

endmodule

[test/signed_binary_to_decimal_ascii_tb.sv]
// Testbench for the signed binary to decimal ASCII converter: scoreboard, stimulus and checks.
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii_tb;

	localparam logic [sbda_pkg::APB_ADDR_W-1:0] ADDR_BUFFER_SIZE =
		{sbda_pkg::REG_BUFFER_SIZE, 2'b00};
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_CYCLES  = 400;

	typedef struct {
		logic [sbda_pkg::CHAR_W-1:0] code;
		logic                        last;
	} ascii_char_t;

	class ascii_scoreboard;
		logic [sbda_pkg::CFG_SIZE_W-1:0] buffer_size;
		ascii_char_t                     pending_chars[$];
		int                              errors;
		int                              values_noted;
		int                              chars_checked;

		function new();
			buffer_size   = sbda_pkg::BUFFER_SIZE_RST;
			errors        = 0;
			values_noted  = 0;
			chars_checked = 0;
		endfunction

		function void push_char(logic [sbda_pkg::CHAR_W-1:0] code, logic last);
			ascii_char_t c;
			c.code = code;
			c.last = last;
			pending_chars.push_back(c);
		endfunction

		// Predicts the character run for one accepted value.
		function void note_value(logic [sbda_pkg::VALUE_W-1:0] v);
			logic                          neg;
			logic [sbda_pkg::VALUE_W-1:0]  mag;
			logic [sbda_pkg::CHAR_W-1:0]   digits[$];
			int                            cap;
			int                            visible;
			neg = v[sbda_pkg::VALUE_W-1];
			mag = neg ? (~v + 1'b1) : v;
			cap = (buffer_size > sbda_pkg::MAX_CHARS_DEF) ? sbda_pkg::MAX_CHARS_DEF
			                                              : int'(buffer_size);
			visible = 0;
			values_noted++;
			if (cap == 0) return;
			do begin
				digits.push_back(sbda_pkg::CH_ZERO + sbda_pkg::CHAR_W'(mag % 10));
				mag = mag / 10;
			end while (mag != 0);
			if (neg && visible + 1 < cap) begin
				push_char(sbda_pkg::CH_MINUS, 1'b0);
				visible++;
			end
			while (digits.size() != 0 && visible + 1 < cap) begin
				push_char(digits.pop_back(), 1'b0);
				visible++;
			end
			push_char(sbda_pkg::CH_NUL, 1'b1);
		endfunction

		function void check_char(logic [sbda_pkg::CHAR_W-1:0] code, logic last);
			ascii_char_t exp_c;
			chars_checked++;
			if (pending_chars.size() == 0) begin
				$error("unexpected char transaction: char_code %0h last %0b", code, last);
				errors++;
				return;
			end
			exp_c = pending_chars.pop_front();
			if (code !== exp_c.code) begin
				$error("char_code mismatch: expected %0h actual %0h", exp_c.code, code);
				errors++;
			end
			if (last !== exp_c.last) begin
				$error("last mismatch: expected %0b actual %0b", exp_c.last, last);
				errors++;
			end
		endfunction

		function int pending();
			return pending_chars.size();
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic [sbda_pkg::VALUE_W-1:0]    value;
	logic                            value_valid;
	logic                            value_ready;
	logic [sbda_pkg::CHAR_W-1:0]     char_code;
	logic                            last;
	logic                            char_valid;
	logic                            char_ready;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [sbda_pkg::APB_ADDR_W-1:0] paddr;
	logic [sbda_pkg::APB_DATA_W-1:0] pwdata;
	logic [sbda_pkg::APB_DATA_W-1:0] prdata;
	logic                            pready;

	ascii_scoreboard sb;
	int  send_idle_pct;
	int  recv_idle_pct;
	int  sizes_used;
	bit  hold_req;
	logic hold_on;

	signed_binary_to_decimal_ascii DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (value),
		.value_valid (value_valid),
		.value_ready (value_ready),
		.char_code   (char_code),
		.last        (last),
		.char_valid  (char_valid),
		.char_ready  (char_ready),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// output side: random ready, checks on each accepted transaction
	always @(posedge clk) begin
		if (arst_n && char_valid && char_ready)
			sb.check_char(char_code, last);
		char_ready <= !hold_on && ($urandom_range(99) >= recv_idle_pct);
	end

	// long output hold-off so the converter backs up and stalls its input
	initial begin
		hold_on = 1'b0;
		wait (hold_req);
		@(posedge clk);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_on <= 1'b0;
	end

	initial begin
		#12_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic send_value(input logic [sbda_pkg::VALUE_W-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			value_valid <= 1'b0;
			@(posedge clk);
		end
		value       <= v;
		value_valid <= 1'b1;
		@(posedge clk);
		while (!value_ready) @(posedge clk);
		sb.note_value(v);
	endtask

	task automatic drain();
		value_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [sbda_pkg::APB_ADDR_W-1:0] addr,
		input logic [sbda_pkg::APB_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apb_read(input logic [sbda_pkg::APB_ADDR_W-1:0] addr,
		output logic [sbda_pkg::APB_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_buffer_size();
		logic [sbda_pkg::APB_DATA_W-1:0] rd;
		apb_read(ADDR_BUFFER_SIZE, rd);
		if (rd[sbda_pkg::CFG_SIZE_W-1:0] !== sb.buffer_size) begin
			$error("buffer_size readback mismatch: expected %0d actual %0d",
				sb.buffer_size, rd[sbda_pkg::CFG_SIZE_W-1:0]);
			sb.errors++;
		end
	endtask

	task automatic set_buffer_size(input int size);
		drain();
		apb_write(ADDR_BUFFER_SIZE, sbda_pkg::APB_DATA_W'(size));
		sb.buffer_size = sbda_pkg::CFG_SIZE_W'(size);
		sizes_used++;
		check_buffer_size();
	endtask

	function automatic logic [sbda_pkg::VALUE_W-1:0] rand_value();
		logic [sbda_pkg::VALUE_W-1:0] v;
		logic [sbda_pkg::VALUE_W-1:0] p;
		p = 1;
		case ($urandom_range(5))
			0: begin
				v = $urandom_range(99);
				if ($urandom_range(1)) v = -v;
			end
			1: begin
				repeat ($urandom_range(9)) p = p * 10;
				v = p + $urandom_range(2) - 1;
				if ($urandom_range(1)) v = -v;
			end
			2: begin
				case ($urandom_range(2))
					0: v = 32'h8000_0000 + $urandom_range(3);
					1: v = 32'h7fff_ffff - $urandom_range(3);
					default: v = $urandom_range(3) - 2;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic run_random(input int size, input int count);
		set_buffer_size(size);
		repeat (count) send_value(rand_value());
	endtask

	logic [sbda_pkg::VALUE_W-1:0] dir_vals[12] = '{32'h0, 32'hffff_ffff, 32'h1, 32'h7fff_ffff,
		32'h8000_0000, 32'd9, 32'd10, -32'sd10, 32'd1000000000, -32'sd999999999,
		32'h5555_5555, 32'haaaa_aaaa};

	initial begin
		arst_n        = 1'b0;
		value         = '0;
		value_valid   = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		send_idle_pct = 19;
		recv_idle_pct = 80;
		sizes_used    = 0;
		hold_req      = 1'b0;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset size, then sign cap, zero size, oversize, truncation
		check_buffer_size();
		foreach (dir_vals[i]) send_value(dir_vals[i]);
		set_buffer_size(1);
		send_value(-32'sd5);
		send_value(32'd7);
		set_buffer_size(2);
		send_value(-32'sd5);
		send_value(32'd3);
		set_buffer_size(0);
		send_value(32'd123);
		send_value(32'hffff_ffff);
		set_buffer_size(15);
		send_value(32'h8000_0000);
		send_value(32'h7fff_ffff);
		set_buffer_size(5);
		send_value(32'd123456789);
		send_value(-32'sd123456789);
		set_buffer_size(13);
		send_value(-32'sd1000000000);

		run_random(12, 70);
		run_random(3, 40);
		run_random(0, 20);

		drain();
		send_idle_pct = 80;
		recv_idle_pct = 19;
		run_random(14, 70);
		run_random(7, 40);
		run_random(1, 20);

		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_buffer_size(12);
		hold_req = 1'b1;
		repeat (30) send_value(rand_value());
		run_random(11, 30);
		run_random(2, 30);
		run_random(15, 30);
		run_random(9, 30);
		drain();

		$display("Converted %0d values over %0d buffer size writes, %0d characters compared",
			sb.values_noted, sizes_used, sb.chars_checked);
		$display("Idle mixes on both sides plus a %0d-cycle output hold-off", HOLD_CYCLES);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[sim.f]
rtl/sbda_pkg.sv
rtl/sbda_digit_cell.sv
rtl/signed_binary_to_decimal_ascii.sv
test/signed_binary_to_decimal_ascii_tb.sv
